[hw/rtl/double_ended_queue_assert.svh]
// assertion macros for the double-ended queue checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/deq_pkg.sv]
// shared constants for the double-ended queue: sizes, field widths and codes
// used by the top level and its checker; no dependencies
package deq_pkg;

    // ring geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // item field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // stored word width, the push value keeps at most its own width
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    // packed stream widths, rounded up to whole bytes
    localparam int S_FIELDS_W = CMD_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + COUNT_W + 1 + 2 * VALUE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // output field offsets
    localparam int M_COUNT_LSB = STATUS_W;
    localparam int M_EMPTY_BIT = STATUS_W + COUNT_W;
    localparam int M_FRONT_LSB = M_EMPTY_BIT + 1;
    localparam int M_BACK_LSB  = M_FRONT_LSB + VALUE_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

[hw/rtl/deq_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/double_ended_queue.sv]
// Bounded double-ended queue on a ring held in one synchronous ram.
// A push, a refused command or a pop that empties the queue loads its item into the output
// register on acceptance; a pop that leaves entries first reads the new end word from the
// ring ram, then loads the item in the read state. Throughput: one item per cycle when the
// output is not stalled; a pop that leaves entries holds off commands in its read state.
// Reset (i_rst_n low, synchronous) empties the queue; the ring ram is not cleared.
module double_ended_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command [1:0], push_value [33:2], zero pad [39:34]
    input  logic [deq_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // status [1:0], count_after [6:2], is_empty [7], front_value [39:8], back_value [71:40]
    output logic [deq_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam int IDX_W   = deq_pkg::IDX_W;
    localparam int CNT_W   = deq_pkg::CNT_W;
    localparam int STORE_W = deq_pkg::STORE_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(deq_pkg::DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(deq_pkg::DEPTH);
    localparam logic [CNT_W-1:0] ZERO_CNT  = '0;
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // ring index steps with wrap
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    logic                r_state;
    logic [IDX_W-1:0]    r_front_idx;
    logic [IDX_W-1:0]    r_back_idx;
    logic [CNT_W-1:0]    r_count;
    logic                r_rd_front;
    logic [STORE_W-1:0]  r_front_val;
    logic [STORE_W-1:0]  r_back_val;

    logic                      r_out_valid;
    logic [deq_pkg::STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]          r_out_count;
    logic [STORE_W-1:0]        r_out_front;
    logic [STORE_W-1:0]        r_out_back;

    logic [IDX_W-1:0]    n_front_idx;
    logic [IDX_W-1:0]    n_back_idx;
    logic [CNT_W-1:0]    n_count;
    logic [STORE_W-1:0]  n_front_val;
    logic [STORE_W-1:0]  n_back_val;
    logic [deq_pkg::STATUS_W-1:0] n_status;
    logic                n_need_rd;
    logic                n_rd_front;

    logic                      s_ready;
    logic                      s_accept;
    logic                      m_take;
    logic [deq_pkg::CMD_W-1:0] cmd;
    logic [STORE_W-1:0]        word;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    // handshake
    assign s_ready  = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept = i_s_tvalid && s_ready;
    assign m_take   = r_out_valid && i_m_tready;
    assign cmd      = i_s_tdata[deq_pkg::CMD_W-1:0];
    assign word     = i_s_tdata[deq_pkg::CMD_W +: STORE_W];

    // command decode: new pointers, count, cached end words and ram access
    always_comb begin
        n_front_idx = r_front_idx;
        n_back_idx  = r_back_idx;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_status    = deq_pkg::ST_DONE;
        n_need_rd   = 1'b0;
        n_rd_front  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_front_idx;
        ram_raddr   = r_front_idx;
        unique case (cmd)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                if (r_count == FULL_CNT) begin
                    n_status = deq_pkg::ST_FULL;
                end else if (r_count == ZERO_CNT) begin
                    // first entry sits at the front slot, both ends on it
                    ram_we      = 1'b1;
                    ram_waddr   = r_front_idx;
                    n_back_idx  = r_front_idx;
                    n_count     = ONE_CNT;
                    n_front_val = word;
                    n_back_val  = word;
                end else if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
                    ram_we      = 1'b1;
                    ram_waddr   = idx_prev(r_front_idx);
                    n_front_idx = idx_prev(r_front_idx);
                    n_count     = r_count + ONE_CNT;
                    n_front_val = word;
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = idx_next(r_back_idx);
                    n_back_idx  = idx_next(r_back_idx);
                    n_count     = r_count + ONE_CNT;
                    n_back_val  = word;
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                if (r_count == ZERO_CNT) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - ONE_CNT;
                    // the new end word has to come from the ring
                    if (r_count != ONE_CNT) begin
                        n_need_rd = 1'b1;
                        if (cmd == deq_pkg::CMD_POP_FRONT) begin
                            n_rd_front  = 1'b1;
                            n_front_idx = idx_next(r_front_idx);
                            ram_raddr   = idx_next(r_front_idx);
                        end else begin
                            n_back_idx = idx_prev(r_back_idx);
                            ram_raddr  = idx_prev(r_back_idx);
                        end
                    end
                end
            end
            default: begin
                n_status = deq_pkg::ST_DONE;
            end
        endcase
    end

    // ring storage
    deq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we && s_accept),
        .i_waddr (ram_waddr),
        .i_wdata (word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_count     <= '0;
            r_rd_front  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_front_idx <= n_front_idx;
                r_back_idx  <= n_back_idx;
                r_count     <= n_count;
                r_rd_front  <= n_rd_front;
            end
            if (s_accept && n_need_rd) begin
                r_state <= S_READ;
            end else if (r_state == S_READ) begin
                r_state <= S_IDLE;
            end
            // output register: loaded on a finished item, freed when taken
            if ((s_accept && !n_need_rd) || (r_state == S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (m_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cached end words and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_front_val <= n_front_val;
            r_back_val  <= n_back_val;
            if (!n_need_rd) begin
                r_out_status <= n_status;
                r_out_count  <= n_count;
                r_out_front  <= (n_count == ZERO_CNT) ? '0 : n_front_val;
                r_out_back   <= (n_count == ZERO_CNT) ? '0 : n_back_val;
            end
        end else if (r_state == S_READ) begin
            r_out_status <= deq_pkg::ST_DONE;
            r_out_count  <= r_count;
            if (r_rd_front) begin
                r_front_val <= ram_rdata;
                r_out_front <= ram_rdata;
                r_out_back  <= r_back_val;
            end else begin
                r_back_val  <= ram_rdata;
                r_out_front <= r_front_val;
                r_out_back  <= ram_rdata;
            end
        end
    end

    // result packing
    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = deq_pkg::M_TDATA_W'({
        deq_pkg::VALUE_W'(r_out_back),
        deq_pkg::VALUE_W'(r_out_front),
        (r_out_count == ZERO_CNT),
        deq_pkg::COUNT_W'(r_out_count),
        r_out_status
    });

endmodule

[hw/rtl/deq_checker.sv]
// port-level checker for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_assert.svh
`include "double_ended_queue_assert.svh"

module deq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic [deq_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready
);

    localparam int CL = deq_pkg::M_COUNT_LSB;
    localparam int FL = deq_pkg::M_FRONT_LSB;
    localparam int BL = deq_pkg::M_BACK_LSB;

    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::COUNT_W-1:0]  count;
    logic                         empty;
    logic [deq_pkg::VALUE_W-1:0]  front;
    logic [deq_pkg::VALUE_W-1:0]  back;

    assign status = o_m_tdata[deq_pkg::STATUS_W-1:0];
    assign count  = o_m_tdata[CL +: deq_pkg::COUNT_W];
    assign empty  = o_m_tdata[deq_pkg::M_EMPTY_BIT];
    assign front  = o_m_tdata[FL +: deq_pkg::VALUE_W];
    assign back   = o_m_tdata[BL +: deq_pkg::VALUE_W];

    // a waiting item is held until taken
    `DEQ_ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "item dropped or changed while stalled")
    // empty flag agrees with the count, an empty queue shows zero end words
    `DEQ_ASSERT_IMP(a_empty, o_m_tvalid, (empty == (count == '0)) && (!empty || (front == '0 && back == '0)), "empty flag or end words inconsistent")
    // a refused push only happens on a full queue
    `DEQ_ASSERT_IMP(a_full, o_m_tvalid && status == deq_pkg::ST_FULL, count == deq_pkg::COUNT_W'(deq_pkg::DEPTH), "full status with room left")
    // a refused pop only happens on an empty queue
    `DEQ_ASSERT_IMP(a_pop_empty, o_m_tvalid && status == deq_pkg::ST_EMPTY, empty, "empty status on a non-empty queue")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
